// File: sv/utf8v_pkg.sv
package utf8v_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_END       = 3'd1,
      ST_TRUNC     = 3'd2,
      ST_INVALID   = 3'd3,
      ST_OVERLONG  = 3'd4,
      ST_SURROGATE = 3'd5,
      ST_RANGE     = 3'd6
   } status_type;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int OFS_OUT_W = 32;
   localparam int CP_W = 21;
   localparam int CNT_W = 32;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // One result beat
   typedef struct packed {
      status_type             status;
      logic [CP_W-1:0]        code_point;
      logic [OFS_OUT_W-1:0]   start_offset;
      logic [CNT_W-1:0]       point_count;
      logic                   run_last;
   } rsp_entry_type;

   // Results produced by one input beat, in order
   typedef struct packed {
      rsp_entry_type first;
      rsp_entry_type second;
      logic          first_valid;
      logic          second_valid;
   } push_type;

endpackage

// File: sv/utf8_stream_decoder_validator.sv
// Strict streaming UTF-8 decoder: one buffer byte per req beat, req_last_byte on the
// buffer's final byte. Each completed sequence yields an ok beat (code point and byte
// offset of its first byte) or an error beat (invalid, overlong, surrogate, out of
// range); after an error the rest of the buffer yields nothing. The final byte adds an
// END beat carrying the buffer length and the count of code points, preceded by a
// truncated beat if a sequence was left open. rsp_run_last marks the last beat caused by
// one input byte. A byte is decoded in the cycle it is accepted and its first result can
// appear on rsp_ the next cycle, behind any results already queued. Results drain one per
// cycle while rsp_ready is high from a four-entry queue and req_ready is high while it
// holds two or fewer, so with rsp_ready held high a byte is taken every cycle; the input
// is held back only when a buffer end that gives two results finds two results already
// queued. Offsets and counts saturate.
module utf8_stream_decoder_validator #(
   parameter int OFFSET_BITS = utf8v_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_byte_in,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [utf8v_pkg::CP_W-1:0]        rsp_code_point,
   output logic [utf8v_pkg::OFS_OUT_W-1:0]   rsp_start_offset,
   output logic [utf8v_pkg::CNT_W-1:0]       rsp_point_count,
   output logic                              rsp_run_last
);

   utf8v_pkg::push_type       push;
   utf8v_pkg::rsp_entry_type  head;
   logic                      room;
   logic                      beat_accept;

   assign req_ready   = room;
   assign beat_accept = req_valid && room;

   utf8v_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .beat_byte   (req_byte_in),
      .beat_last   (req_last_byte),
      .push        (push)
   );

   utf8v_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head       (head),
      .head_valid (rsp_valid),
      .head_pop   (rsp_ready)
   );

   assign rsp_status       = head.status;
   assign rsp_code_point   = head.code_point;
   assign rsp_start_offset = head.start_offset;
   assign rsp_point_count  = head.point_count;
   assign rsp_run_last     = head.run_last;

endmodule

// File: sv/utf8v_core.sv
module utf8v_core #(
   parameter int OFFSET_BITS = utf8v_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_accept,
   input  logic [7:0]          beat_byte,
   input  logic                beat_last,
   output utf8v_pkg::push_type push
);

   localparam int EXT_W = (OFFSET_BITS > utf8v_pkg::OFS_OUT_W) ? OFFSET_BITS
                                                                : utf8v_pkg::OFS_OUT_W;

   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [7:0] LEAD_C0     = 8'hC0;
   localparam logic [7:0] LEAD_C1     = 8'hC1;
   localparam logic [7:0] LEAD_SURR   = 8'hED;
   localparam logic [7:0] E0_MIN_2ND  = 8'hA0;
   localparam logic [7:0] ED_MAX_2ND  = 8'h9F;
   localparam logic [7:0] F0_MIN_2ND  = 8'h90;
   localparam logic [7:0] F4_MAX_2ND  = 8'h8F;
   localparam logic [7:0] CONT_MIN    = 8'h80;
   localparam logic [7:0] CONT_MAX    = 8'hBF;

   // Sequence state
   logic [7:0]                      held_ff [3];
   logic [7:0]                      held_in [3];
   logic [2:0]                      needed_ff, needed_in;
   logic [1:0]                      held_cnt_ff, held_cnt_in;
   logic                            error_ff, error_in;
   logic [OFFSET_BITS-1:0]          pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]          start_ff, start_in;
   logic [utf8v_pkg::CNT_W-1:0]     count_ff, count_in;

   // Per-beat working values
   logic                            seq_valid;
   utf8v_pkg::status_type           seq_status;
   logic [utf8v_pkg::CP_W-1:0]      seq_cp;
   logic [7:0]                      s1, s2, s3;
   logic                            cont_ok;
   logic                            trunc_valid;
   logic [OFFSET_BITS-1:0]          pos_inc;
   logic [utf8v_pkg::CNT_W-1:0]     count_inc;
   logic [EXT_W-1:0]                start_wide, end_wide;
   utf8v_pkg::rsp_entry_type        e_seq, e_trunc, e_end;

   function automatic logic is_cont(input logic [7:0] b);
      return (b >= CONT_MIN) && (b <= CONT_MAX);
   endfunction

   // Decode one beat against the held sequence
   always_comb begin
      held_in     = held_ff;
      needed_in   = needed_ff;
      held_cnt_in = held_cnt_ff;
      error_in    = error_ff;
      start_in    = start_ff;
      seq_valid   = 1'b0;
      seq_status  = utf8v_pkg::ST_OK;
      seq_cp      = '0;
      s1          = (needed_ff == 3'd2) ? beat_byte : held_ff[1];
      s2          = (needed_ff == 3'd3) ? beat_byte : held_ff[2];
      s3          = beat_byte;
      cont_ok     = is_cont(s1);
      if (needed_ff >= 3'd3) begin
         cont_ok = cont_ok && is_cont(s2);
      end
      if (needed_ff == 3'd4) begin
         cont_ok = cont_ok && is_cont(s3);
      end

      if (beat_accept && !error_ff) begin
         if (needed_ff == 3'd0) begin
            // lead byte
            start_in = pos_ff;
            if (beat_byte <= ASCII_MAX) begin
               seq_valid = 1'b1;
               seq_cp    = utf8v_pkg::CP_W'(beat_byte);
            end else if (beat_byte >= LEAD2_MIN && beat_byte <= LEAD2_MAX) begin
               needed_in = 3'd2;
            end else if (beat_byte >= LEAD3_MIN && beat_byte <= LEAD3_MAX) begin
               needed_in = 3'd3;
            end else if (beat_byte >= LEAD4_MIN && beat_byte <= LEAD4_MAX) begin
               needed_in = 3'd4;
            end else if (beat_byte == LEAD_C0 || beat_byte == LEAD_C1) begin
               seq_valid  = 1'b1;
               seq_status = utf8v_pkg::ST_OVERLONG;
               error_in   = 1'b1;
            end else if (beat_byte > LEAD4_MAX) begin
               seq_valid  = 1'b1;
               seq_status = utf8v_pkg::ST_RANGE;
               error_in   = 1'b1;
            end else begin
               seq_valid  = 1'b1;
               seq_status = utf8v_pkg::ST_INVALID;
               error_in   = 1'b1;
            end
            if (needed_in != 3'd0) begin
               held_in[0]  = beat_byte;
               held_cnt_in = 2'd1;
            end
         end else if ({1'b0, held_cnt_ff} + 3'd1 >= needed_ff) begin
            // final byte: check continuation, then forms
            seq_valid   = 1'b1;
            needed_in   = 3'd0;
            held_cnt_in = 2'd0;
            if (!cont_ok) begin
               seq_status = utf8v_pkg::ST_INVALID;
            end else if (needed_ff == 3'd2) begin
               seq_cp = {10'd0, held_ff[0][4:0], s1[5:0]};
            end else if (needed_ff == 3'd3) begin
               if (held_ff[0] == LEAD3_MIN && s1 < E0_MIN_2ND) begin
                  seq_status = utf8v_pkg::ST_OVERLONG;
               end else if (held_ff[0] == LEAD_SURR && s1 > ED_MAX_2ND) begin
                  seq_status = utf8v_pkg::ST_SURROGATE;
               end else begin
                  seq_cp = {5'd0, held_ff[0][3:0], s1[5:0], s2[5:0]};
               end
            end else begin
               if (held_ff[0] == LEAD4_MIN && s1 < F0_MIN_2ND) begin
                  seq_status = utf8v_pkg::ST_OVERLONG;
               end else if (held_ff[0] == LEAD4_MAX && s1 > F4_MAX_2ND) begin
                  seq_status = utf8v_pkg::ST_RANGE;
               end else begin
                  seq_cp = {held_ff[0][2:0], s1[5:0], s2[5:0], s3[5:0]};
               end
            end
            if (seq_status != utf8v_pkg::ST_OK) begin
               error_in = 1'b1;
            end
         end else begin
            // middle continuation byte
            held_in[held_cnt_ff] = beat_byte;
            held_cnt_in          = held_cnt_ff + 2'd1;
         end
      end

      // saturating counters
      pos_inc   = (&pos_ff) ? pos_ff : pos_ff + OFFSET_BITS'(1);
      count_inc = count_ff;
      if (seq_valid && seq_status == utf8v_pkg::ST_OK && !(&count_ff)) begin
         count_inc = count_ff + utf8v_pkg::CNT_W'(1);
      end
      trunc_valid = beat_accept && beat_last && !error_in && (needed_in != 3'd0);
      start_wide  = EXT_W'(start_in);
      end_wide    = EXT_W'(pos_inc);

      // result beats
      e_seq.status         = seq_status;
      e_seq.code_point     = seq_cp;
      e_seq.start_offset   = start_wide[utf8v_pkg::OFS_OUT_W-1:0];
      e_seq.point_count    = '0;
      e_seq.run_last       = !beat_last;
      e_trunc.status       = utf8v_pkg::ST_TRUNC;
      e_trunc.code_point   = '0;
      e_trunc.start_offset = start_wide[utf8v_pkg::OFS_OUT_W-1:0];
      e_trunc.point_count  = '0;
      e_trunc.run_last     = 1'b0;
      e_end.status         = utf8v_pkg::ST_END;
      e_end.code_point     = '0;
      e_end.start_offset   = end_wide[utf8v_pkg::OFS_OUT_W-1:0];
      e_end.point_count    = count_inc;
      e_end.run_last       = 1'b1;

      push.second       = e_end;
      push.second_valid = 1'b0;
      if (seq_valid) begin
         push.first        = e_seq;
         push.first_valid  = 1'b1;
         push.second_valid = beat_accept && beat_last;
      end else if (trunc_valid) begin
         push.first        = e_trunc;
         push.first_valid  = 1'b1;
         push.second_valid = 1'b1;
      end else begin
         push.first        = e_end;
         push.first_valid  = beat_accept && beat_last;
      end

      // next counters; buffer end clears the open sequence, error flag, offsets and count
      pos_in   = pos_ff;
      count_in = count_ff;
      if (beat_accept) begin
         pos_in   = pos_inc;
         count_in = count_inc;
         if (beat_last) begin
            needed_in   = 3'd0;
            held_cnt_in = 2'd0;
            error_in    = 1'b0;
            pos_in      = '0;
            start_in    = '0;
            count_in    = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff   <= 3'd0;
         held_cnt_ff <= 2'd0;
         error_ff    <= 1'b0;
         pos_ff      <= '0;
         start_ff    <= '0;
         count_ff    <= '0;
      end else begin
         needed_ff   <= needed_in;
         held_cnt_ff <= held_cnt_in;
         error_ff    <= error_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         count_ff    <= count_in;
      end
   end

   // Held sequence bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff[0] <= 8'h00;
         held_ff[1] <= 8'h00;
         held_ff[2] <= 8'h00;
      end else begin
         held_ff <= held_in;
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == 3'd0) |-> (held_cnt_ff == 2'd0))
      else $error("bytes held with no open sequence");

   a_open_fill: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != 3'd0) |-> (held_cnt_ff != 2'd0 && {1'b0, held_cnt_ff} < needed_ff))
      else $error("held count out of range for open sequence");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (beat_accept && beat_last) |=> (pos_ff == '0 && !error_ff && count_ff == '0))
      else $error("buffer state not cleared after last beat");

endmodule

// File: sv/utf8v_rsp_fifo.sv
module utf8v_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  utf8v_pkg::push_type       push,
   output logic                      room,
   output utf8v_pkg::rsp_entry_type  head,
   output logic                      head_valid,
   input  logic                      head_pop
);

   utf8v_pkg::rsp_entry_type            slot_ff [utf8v_pkg::RSP_DEPTH];
   logic [utf8v_pkg::RSP_PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [utf8v_pkg::RSP_CNT_W-1:0]     count_ff, count_in;
   logic [utf8v_pkg::RSP_PTR_W-1:0]     wr_next;
   logic [utf8v_pkg::RSP_CNT_W-1:0]     push_n;
   logic                                pop;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_next    = wr_ff + utf8v_pkg::RSP_PTR_W'(1);
      push_n     = utf8v_pkg::RSP_CNT_W'(push.first_valid) +
                   utf8v_pkg::RSP_CNT_W'(push.second_valid);
      head_valid = (count_ff != '0);
      pop        = head_valid && head_pop;
      wr_in      = wr_ff + utf8v_pkg::RSP_PTR_W'(push_n);
      rd_in      = pop ? rd_ff + utf8v_pkg::RSP_PTR_W'(1) : rd_ff;
      count_in   = count_ff + push_n - utf8v_pkg::RSP_CNT_W'(pop);
      room       = (count_ff <= utf8v_pkg::RSP_CNT_W'(utf8v_pkg::RSP_DEPTH - 2));
      head       = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Result slots, up to two written per cycle
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utf8v_pkg::RSP_CNT_W'(utf8v_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second result without first");

endmodule
